[hw/rtl/tle_pkg.sv]
// shared constants and types of the tour length evaluator
// no dependencies; imported by the evaluator top module
`default_nettype none

package tle_pkg;

    // fixed field widths
    localparam int NODE_W      = 10;
    localparam int SUM_W       = 36;
    localparam int OUT_TDATA_W = ((SUM_W + 7) / 8) * 8;

    // the sum of squares saturates at this width before the root
    localparam int RAD_LIMIT   = 64;

    // tour tag held per node in the mark memory
    localparam int EPOCH_W     = 8;

    // word kinds on the input side
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TOUR = 1'b1;

    // status codes on the output side
    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_REPEAT = 1'b1;

    typedef logic [SUM_W-1:0]   t_sum;
    typedef logic [EPOCH_W-1:0] t_epoch;

    localparam t_sum SUM_MAX = '1;

endpackage

`default_nettype wire

[hw/rtl/tle_ram.sv]
// generic simple dual-port ram, one write and one registered read port
// depends on nothing; used for the coordinate table and the mark memory
`default_nettype none

module tle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[hw/rtl/tle_isqrt.sv]
// digit-serial integer square root, one root bit per cycle
// radicand shifts out two bits a cycle; depends on nothing else
`default_nettype none

module tle_isqrt #(
    parameter int RAD_W = 49
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [RAD_W-1:0]         i_radicand,
    output logic                          o_done,
    output logic      [(RAD_W+1)/2-1:0]   o_root
);

    localparam int ROOT_W = (RAD_W + 1) / 2;
    localparam int PAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 2;
    localparam int CNT_W  = $clog2(ROOT_W);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [PAD_W-1:0]  r_rad, n_rad;
    logic [REM_W-1:0]  r_rem, n_rem;
    logic [ROOT_W-1:0] r_root, n_root;

    logic [REM_W-1:0]  w_rem_sh;
    logic [REM_W-1:0]  w_trial;

    // bring down the next radicand digit and form the trial subtrahend
    assign w_rem_sh = {r_rem[REM_W-3:0], r_rad[PAD_W-1 -: 2]};
    assign w_trial  = {r_root, 2'b01};

    // one restoring step per cycle
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rad  = r_rad;
        n_rem  = r_rem;
        n_root = r_root;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(ROOT_W - 1);
            n_rad  = PAD_W'(i_radicand);
            n_rem  = '0;
            n_root = '0;
        end else if (r_busy) begin
            n_rad = r_rad << 2;
            if (w_rem_sh >= w_trial) begin
                n_rem  = w_rem_sh - w_trial;
                n_root = {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                n_rem  = w_rem_sh;
                n_root = {r_root[ROOT_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

[hw/rtl/tour_length_evaluator.sv]
// a tour word with a previous node passes the quotient, address, read, square, radicand, root
// and accumulate states; the next word is taken only once the sequencer is idle again
// a load word passes only the quotient and address states; the serial square root sets the rate
// reset is synchronous, active low; afterwards a mark-clearing pass over all MAX_NODES marks
// holds off input, and the same pass runs again after every 255 results
`default_nettype none

module tour_length_evaluator #(
    parameter int MAX_NODES  = 1024,
    parameter int COORD_BITS = 24
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    // input words
    input  wire logic i_s_tvalid,
    output logic      o_s_tready,
    // node, x_coord, y_coord from bit 0 up
    input  wire logic [((tle_pkg::NODE_W + 2 * COORD_BITS + 7) / 8) * 8 - 1:0] i_s_tdata,
    // kind
    input  wire logic i_s_tuser,
    // last
    input  wire logic i_s_tlast,
    // result words
    output logic      o_m_tvalid,
    input  wire logic i_m_tready,
    // tour_length
    output logic [tle_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    // status
    output logic      o_m_tuser
);

    import tle_pkg::*;

    localparam int CB        = COORD_BITS;
    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int SQ_SUM_W  = 2 * CB + 1;
    localparam int RAD_W     = (SQ_SUM_W > RAD_LIMIT) ? RAD_LIMIT : SQ_SUM_W;
    localparam int ROOT_W    = (RAD_W + 1) / 2;

    // sequencer codes
    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_QUOT   = 4'd2;
    localparam logic [3:0] S_ADDR   = 4'd3;
    localparam logic [3:0] S_READ   = 4'd4;
    localparam logic [3:0] S_SQUARE = 4'd5;
    localparam logic [3:0] S_RAD    = 4'd6;
    localparam logic [3:0] S_ROOT   = 4'd7;
    localparam logic [3:0] S_ACC    = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    logic [3:0]        r_state, n_state;
    logic [IDX_W-1:0]  r_clr_addr, n_clr_addr;
    t_epoch            r_epoch, n_epoch;
    logic              r_kind, n_kind;
    logic [NODE_W-1:0] r_node, n_node;
    logic [CB-1:0]     r_x, n_x;
    logic [CB-1:0]     r_y, n_y;
    logic              r_last, n_last;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [CB-1:0]     r_prev_x, n_prev_x;
    logic [CB-1:0]     r_prev_y, n_prev_y;
    logic              r_have_prev, n_have_prev;
    logic              r_repeat, n_repeat;
    logic [CB-1:0]     r_dx, n_dx;
    logic [CB-1:0]     r_dy, n_dy;
    logic [2*CB-1:0]   r_sx, n_sx;
    logic [2*CB-1:0]   r_sy, n_sy;
    t_sum              r_sum, n_sum;
    logic              r_out_valid, n_out_valid;
    t_sum              r_out_len, n_out_len;
    logic              r_out_status, n_out_status;

    logic [IDX_W-1:0]  w_idx;
    logic              w_in_acc;
    logic              w_out_free;
    logic [2*CB-1:0]   w_coord_rdata;
    t_epoch            w_mark_rdata;
    logic              w_mark_hit;
    logic [CB-1:0]     w_cx, w_cy;
    logic signed [CB:0] w_dx_diff, w_dy_diff;
    logic [SQ_SUM_W-1:0] w_sq_sum;
    logic [RAD_W-1:0]  w_rad;
    logic              w_sqrt_start;
    logic              w_sqrt_done;
    logic [ROOT_W-1:0] w_root;
    logic [SUM_W:0]    w_acc;
    t_epoch            w_epoch_inc;

    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;

    // node number modulo the table depth
    if (MAX_NODES < (1 << NODE_W)) begin : g_idx_mod
        localparam int RECIP_SH = 2 * NODE_W;
        localparam int PROD_W   = NODE_W + RECIP_SH + 1;
        localparam logic [RECIP_SH:0] RECIP =
            (RECIP_SH + 1)'(((1 << RECIP_SH) + MAX_NODES - 1) / MAX_NODES);

        logic [NODE_W-1:0]   r_quot;
        logic [PROD_W-1:0]   w_quot_prod;
        logic [2*NODE_W-1:0] w_back;
        logic [2*NODE_W-1:0] w_rem;

        // quotient by reciprocal, exact for every node number
        assign w_quot_prod = PROD_W'(r_node) * PROD_W'(RECIP);

        always_ff @(posedge i_clk) begin
            r_quot <= w_quot_prod[RECIP_SH +: NODE_W];
        end

        assign w_back = (2 * NODE_W)'(r_quot) * (2 * NODE_W)'(MAX_NODES);
        assign w_rem  = (2 * NODE_W)'(r_node) - w_back;
        assign w_idx  = w_rem[IDX_W-1:0];
    end else begin : g_idx_direct
        assign w_idx = IDX_W'(r_node);
    end

    // coordinate table, {y, x} per node
    tle_ram #(
        .WIDTH (2 * CB),
        .DEPTH (MAX_NODES)
    ) u_coord_ram (
        .i_clk     (i_clk),
        .i_wr_en   (r_state == S_ADDR && r_kind == KIND_LOAD),
        .i_wr_addr (w_idx),
        .i_wr_data ({r_y, r_x}),
        .i_rd_en   (r_state == S_ADDR && r_kind == KIND_TOUR),
        .i_rd_addr (w_idx),
        .o_rd_data (w_coord_rdata)
    );

    // visit marks, a node is marked when it holds the current tour tag
    tle_ram #(
        .WIDTH (EPOCH_W),
        .DEPTH (MAX_NODES)
    ) u_mark_ram (
        .i_clk     (i_clk),
        .i_wr_en   (r_state == S_CLEAR || r_state == S_READ),
        .i_wr_addr ((r_state == S_CLEAR) ? r_clr_addr : r_idx),
        .i_wr_data ((r_state == S_CLEAR) ? t_epoch'(0) : r_epoch),
        .i_rd_en   (r_state == S_ADDR && r_kind == KIND_TOUR),
        .i_rd_addr (w_idx),
        .o_rd_data (w_mark_rdata)
    );

    assign w_mark_hit = (w_mark_rdata == r_epoch);
    assign w_cx       = w_coord_rdata[CB-1:0];
    assign w_cy       = w_coord_rdata[2*CB-1:CB];

    // signed coordinate differences
    assign w_dx_diff = $signed({w_cx[CB-1], w_cx}) - $signed({r_prev_x[CB-1], r_prev_x});
    assign w_dy_diff = $signed({w_cy[CB-1], w_cy}) - $signed({r_prev_y[CB-1], r_prev_y});

    // sum of squares, saturated to the root unit's width
    assign w_sq_sum = {1'b0, r_sx} + {1'b0, r_sy};

    if (SQ_SUM_W > RAD_W) begin : g_rad_sat
        assign w_rad = (|w_sq_sum[SQ_SUM_W-1:RAD_W]) ? '1 : w_sq_sum[RAD_W-1:0];
    end else begin : g_rad_plain
        assign w_rad = w_sq_sum;
    end

    assign w_sqrt_start = (r_state == S_RAD);

    tle_isqrt #(
        .RAD_W (RAD_W)
    ) u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_sqrt_start),
        .i_radicand (w_rad),
        .o_done     (w_sqrt_done),
        .o_root     (w_root)
    );

    // saturating accumulation of the edge length
    assign w_acc       = {1'b0, r_sum} + (SUM_W + 1)'(w_root);
    assign w_epoch_inc = r_epoch + 1'b1;

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_epoch      = r_epoch;
        n_kind       = r_kind;
        n_node       = r_node;
        n_x          = r_x;
        n_y          = r_y;
        n_last       = r_last;
        n_idx        = r_idx;
        n_prev_x     = r_prev_x;
        n_prev_y     = r_prev_y;
        n_have_prev  = r_have_prev;
        n_repeat     = r_repeat;
        n_dx         = r_dx;
        n_dy         = r_dy;
        n_sx         = r_sx;
        n_sy         = r_sy;
        n_sum        = r_sum;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_len    = r_out_len;
        n_out_status = r_out_status;

        unique case (r_state)
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == IDX_W'(MAX_NODES - 1)) begin
                    n_state = S_IDLE;
                    n_epoch = t_epoch'(1);
                end
            end
            S_IDLE: begin
                if (w_in_acc) begin
                    n_kind  = i_s_tuser;
                    n_node  = i_s_tdata[NODE_W-1:0];
                    n_x     = i_s_tdata[NODE_W +: CB];
                    n_y     = i_s_tdata[NODE_W + CB +: CB];
                    n_last  = i_s_tlast;
                    n_state = S_QUOT;
                end
            end
            S_QUOT: begin
                n_state = S_ADDR;
            end
            S_ADDR: begin
                n_idx   = w_idx;
                n_state = (r_kind == KIND_LOAD) ? S_IDLE : S_READ;
            end
            S_READ: begin
                n_repeat    = r_repeat || w_mark_hit;
                n_prev_x    = w_cx;
                n_prev_y    = w_cy;
                n_have_prev = 1'b1;
                n_dx = w_dx_diff[CB] ? CB'(-w_dx_diff) : w_dx_diff[CB-1:0];
                n_dy = w_dy_diff[CB] ? CB'(-w_dy_diff) : w_dy_diff[CB-1:0];
                n_state = r_have_prev ? S_SQUARE : S_DONE;
            end
            S_SQUARE: begin
                n_sx    = r_dx * r_dx;
                n_sy    = r_dy * r_dy;
                n_state = S_RAD;
            end
            S_RAD: begin
                n_state = S_ROOT;
            end
            S_ROOT: begin
                if (w_sqrt_done) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                n_sum   = w_acc[SUM_W] ? SUM_MAX : w_acc[SUM_W-1:0];
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_last) begin
                    n_state = S_IDLE;
                end else if (w_out_free) begin
                    // hand over the result and start a fresh tour
                    n_out_valid  = 1'b1;
                    n_out_len    = r_repeat ? SUM_MAX : r_sum;
                    n_out_status = r_repeat ? STATUS_REPEAT : STATUS_OK;
                    n_sum        = '0;
                    n_have_prev  = 1'b0;
                    n_repeat     = 1'b0;
                    n_prev_x     = '0;
                    n_prev_y     = '0;
                    n_epoch      = w_epoch_inc;
                    n_clr_addr   = '0;
                    n_state      = (w_epoch_inc == '0) ? S_CLEAR : S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_epoch     <= '0;
            r_have_prev <= 1'b0;
            r_repeat    <= 1'b0;
            r_sum       <= '0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_epoch     <= n_epoch;
            r_have_prev <= n_have_prev;
            r_repeat    <= n_repeat;
            r_sum       <= n_sum;
            r_prev_x    <= n_prev_x;
            r_prev_y    <= n_prev_y;
            r_out_valid <= n_out_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_node       <= n_node;
        r_x          <= n_x;
        r_y          <= n_y;
        r_last       <= n_last;
        r_idx        <= n_idx;
        r_dx         <= n_dx;
        r_dy         <= n_dy;
        r_sx         <= n_sx;
        r_sy         <= n_sy;
        r_out_len    <= n_out_len;
        r_out_status <= n_out_status;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_TDATA_W'(r_out_len);
    assign o_m_tuser  = r_out_status;

    // the root unit only finishes while the sequencer waits for it
    a_root_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sqrt_done |-> (r_state == S_ROOT))
        else $error("root finished outside its wait state");

    // a repeated tour always reports the saturated length
    a_repeat_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == STATUS_REPEAT) |-> (r_out_len == SUM_MAX))
        else $error("repeat status without saturated length");

    // tour state is cleared once a result is handed over
    a_tour_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_last && w_out_free)
        |=> (!r_have_prev && !r_repeat && r_sum == '0 && r_out_valid))
        else $error("tour state not cleared after result");

    // the zero tag is reserved for cleared marks
    a_epoch_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_CLEAR) |-> (r_epoch != '0))
        else $error("zero tour tag in use");

endmodule

`default_nettype wire
